### hdl/bfr_pkg.sv
`default_nettype none

package bfr_pkg;

   // Default geometry of the console.
   localparam int SCREEN_W_DEFAULT   = 720;
   localparam int SCREEN_H_DEFAULT   = 1280;
   localparam int LINE_PITCH_DEFAULT = 10;

   // Glyph cells are 8 by 8 pixels; 128 glyphs of 8 rows each.
   localparam int GLYPH_SIZE   = 8;
   localparam int GLYPH_COUNT  = 128;
   localparam int GLYPH_DEPTH  = GLYPH_COUNT * GLYPH_SIZE;
   localparam int GLYPH_AW     = $clog2(GLYPH_DEPTH);
   localparam int PIXEL_COUNT  = GLYPH_SIZE * GLYPH_SIZE;
   localparam int PIX_CNT_W    = $clog2(PIXEL_COUNT);
   localparam int ADDR_W       = 20;
   localparam int COLOR_W      = 32;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_FG_COLOR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BG_COLOR = 1'd1;

   localparam logic [COLOR_W-1:0] FG_COLOR_RESET = 32'hFFFF_FFFF;
   localparam logic [COLOR_W-1:0] BG_COLOR_RESET = 32'h0000_00FF;

   // Input transaction kinds.
   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Control characters.
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_RETURN  = 8'h0D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CURSOR,
      ST_SETUP,
      ST_DRAW,
      ST_FILL
   } state_type;

   // Rotate an RGBA word into ARGB order.
   function automatic logic [COLOR_W-1:0] rgba_to_argb(input logic [COLOR_W-1:0] c);
      rgba_to_argb = {c[7:0], c[31:8]};
   endfunction

endpackage

`default_nettype wire

### hdl/bitmap_font_text_renderer.sv
`default_nettype none

// 8x8 bitmap-font text console.
// The req_ channel carries one command per transaction: put a character, load one
// row of a glyph into the internal glyph store, or clear the screen. The rsp_
// channel carries pixel writes and whole-screen fill requests; rsp_tlast marks the
// final result caused by a command. Colors are set through the csr_ write port
// and must only change while the block is idle.
// The block works on one command at a time. A command is taken in the idle cycle,
// the cursor logic of a put runs in the next cycle and the base pixel address is
// formed by one multiply in the cycle after that. A printable character then
// streams 64 pixel writes from the output register, one per cycle while the
// receiver does not stall. Glyph rows come from a 1024 x 8 synchronous memory read
// one row ahead, so the row change does not hold up the pixel stream. Glyph loads,
// newline, carriage return and codes with bit 7 set give no result; clear and a
// bit-7 overflow give a fill; a printable overflow fill rides on its first pixel.
// When rsp_tready is low the output register holds its transaction and the
// drawing sequencer waits. Reset homes the cursor and restores the colors;
// the glyph store is not cleared and must be loaded before use.
module bitmap_font_text_renderer #(
   parameter int SCREEN_W   = bfr_pkg::SCREEN_W_DEFAULT,
   parameter int SCREEN_H   = bfr_pkg::SCREEN_H_DEFAULT,
   parameter int LINE_PITCH = bfr_pkg::LINE_PITCH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Command channel.
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata: char_code[7:0], glyph_row[10:8], glyph_bits[18:11],
   // fill_request_color[50:19], zero padding[55:51].
   input  wire logic [55:0]                     req_tdata,
   // tuser: kind[1:0].
   input  wire logic [1:0]                      req_tuser,
   // Result channel.
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: fill_color[31:0], pixel_address[51:32], pixel_color[83:52],
   // zero padding[87:84].
   output logic [87:0]                          rsp_tdata,
   // tuser: fill_now[0], write_valid[1].
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   // Configuration write port.
   input  wire logic                            csr_we,
   input  wire logic [bfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bfr_pkg::COLOR_W-1:0]     csr_wdata
);

   localparam int CW  = $clog2(SCREEN_W + 1);
   localparam int RW  = $clog2(SCREEN_H + 1);
   localparam int RSW = RW + 6;
   localparam int PW  = (RW + CW > bfr_pkg::ADDR_W) ? RW + CW : bfr_pkg::ADDR_W;
   localparam int AW  = bfr_pkg::ADDR_W;
   localparam int CLW = bfr_pkg::COLOR_W;

   // Unpacked command fields.
   logic [7:0]     req_char_code;
   logic [2:0]     req_glyph_row;
   logic [7:0]     req_glyph_bits;
   logic [CLW-1:0] req_fill_color;
   logic [1:0]     req_kind;
   logic           req_accept;

   assign req_char_code  = req_tdata[7:0];
   assign req_glyph_row  = req_tdata[10:8];
   assign req_glyph_bits = req_tdata[18:11];
   assign req_fill_color = req_tdata[50:19];
   assign req_kind       = req_tuser;
   assign req_accept     = req_tvalid && req_tready;

   // Control and cursor state.
   bfr_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [7:0]         code_ff, code_in;
   logic               fill_ff, fill_in;
   logic [CLW-1:0]     fcol_ff, fcol_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [bfr_pkg::PIX_CNT_W-1:0] pix_ff, pix_in;
   logic [CLW-1:0]     fg_ff, bg_ff;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_fill_ff, out_fill_in;
   logic [CLW-1:0]     out_fcol_ff, out_fcol_in;
   logic               out_wv_ff, out_wv_in;
   logic [AW-1:0]      out_addr_ff, out_addr_in;
   logic [CLW-1:0]     out_pcol_ff, out_pcol_in;
   logic               out_last_ff, out_last_in;

   // Glyph store.
   logic [7:0]                  glyph_mem [bfr_pkg::GLYPH_DEPTH];
   logic [7:0]                  rdata_ff;
   logic [bfr_pkg::GLYPH_AW-1:0] rd_addr;
   logic [bfr_pkg::GLYPH_AW-1:0] wr_addr;
   logic                        wr_en;

   // Cursor arithmetic.
   logic               out_free;
   logic               draw_emit;
   logic [2:0]         pix_col;
   logic [2:0]         pix_row;
   logic [2:0]         bit_sel;
   logic               wrap;
   logic               ovf;
   logic [RSW-1:0]     row_sum;
   logic [RW-1:0]      row_adv;
   logic [CW-1:0]      col_w;
   logic [RW-1:0]      row_w;
   logic [PW-1:0]      base_full;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign draw_emit = (state_ff == bfr_pkg::ST_DRAW) && out_free;
   assign pix_col   = pix_ff[2:0];
   assign pix_row   = pix_ff[5:3];
   assign bit_sel   = 3'd7 - pix_col;

   // Line advance, saturating at the screen height.
   assign row_sum = RSW'(row_ff) + RSW'(LINE_PITCH);
   assign row_adv = (row_sum > RSW'(SCREEN_H)) ? RW'(SCREEN_H) : row_sum[RW-1:0];

   // A character that would cross the right edge wraps first; then a cell that
   // would cross the bottom edge forces a fill and a cursor home.
   assign wrap  = ({1'b0, col_ff} + (CW+1)'(bfr_pkg::GLYPH_SIZE)) > (CW+1)'(SCREEN_W);
   assign col_w = wrap ? '0 : col_ff;
   assign row_w = wrap ? row_adv : row_ff;
   assign ovf   = ({1'b0, row_w} + (RW+1)'(bfr_pkg::GLYPH_SIZE)) > (RW+1)'(SCREEN_H);

   assign base_full = PW'(row_ff) * PW'(SCREEN_W) + PW'(col_ff);

   // The read runs one row ahead: when the last pixel of a row leaves, the next
   // row is addressed so that its bits are ready in the following cycle.
   always_comb begin
      if (draw_emit && pix_col == 3'd7) begin
         rd_addr = {code_ff[6:0], pix_row + 3'd1};
      end else begin
         rd_addr = {code_ff[6:0], pix_row};
      end
   end

   assign wr_en   = req_accept && req_kind == bfr_pkg::KIND_LOAD && !req_char_code[7];
   assign wr_addr = {req_char_code[6:0], req_glyph_row};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         glyph_mem[wr_addr] <= req_glyph_bits;
      end
      rdata_ff <= glyph_mem[rd_addr];
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfr_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_kind)
                  bfr_pkg::KIND_PUT:   state_in = bfr_pkg::ST_CURSOR;
                  bfr_pkg::KIND_CLEAR: state_in = bfr_pkg::ST_FILL;
                  default:             state_in = bfr_pkg::ST_IDLE;
               endcase
            end
         end
         bfr_pkg::ST_CURSOR: begin
            if (code_ff == bfr_pkg::CHAR_NEWLINE || code_ff == bfr_pkg::CHAR_RETURN) begin
               state_in = bfr_pkg::ST_IDLE;
            end else if (code_ff[7]) begin
               state_in = ovf ? bfr_pkg::ST_FILL : bfr_pkg::ST_IDLE;
            end else begin
               state_in = bfr_pkg::ST_SETUP;
            end
         end
         bfr_pkg::ST_SETUP: state_in = bfr_pkg::ST_DRAW;
         bfr_pkg::ST_DRAW: begin
            if (draw_emit && pix_ff == bfr_pkg::PIX_CNT_W'(bfr_pkg::PIXEL_COUNT - 1)) begin
               state_in = bfr_pkg::ST_IDLE;
            end
         end
         bfr_pkg::ST_FILL: begin
            if (out_free) begin
               state_in = bfr_pkg::ST_IDLE;
            end
         end
         default: state_in = bfr_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output logic.
   always_comb begin
      req_tready   = (state_ff == bfr_pkg::ST_IDLE);
      col_in       = col_ff;
      row_in       = row_ff;
      code_in      = code_ff;
      fill_in      = fill_ff;
      fcol_in      = fcol_ff;
      addr_in      = addr_ff;
      pix_in       = pix_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_fill_in  = out_fill_ff;
      out_fcol_in  = out_fcol_ff;
      out_wv_in    = out_wv_ff;
      out_addr_in  = out_addr_ff;
      out_pcol_in  = out_pcol_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         bfr_pkg::ST_IDLE: begin
            if (req_accept) begin
               code_in = req_char_code;
               if (req_kind == bfr_pkg::KIND_CLEAR) begin
                  col_in  = '0;
                  row_in  = '0;
                  fcol_in = bfr_pkg::rgba_to_argb(req_fill_color);
               end
            end
         end
         bfr_pkg::ST_CURSOR: begin
            if (code_ff == bfr_pkg::CHAR_NEWLINE) begin
               col_in = '0;
               row_in = row_adv;
            end else if (code_ff == bfr_pkg::CHAR_RETURN) begin
               col_in = '0;
            end else begin
               col_in  = ovf ? '0 : col_w;
               row_in  = ovf ? '0 : row_w;
               fill_in = ovf;
               fcol_in = bfr_pkg::rgba_to_argb(bg_ff);
            end
         end
         bfr_pkg::ST_SETUP: begin
            addr_in = base_full[AW-1:0];
            pix_in  = '0;
         end
         bfr_pkg::ST_DRAW: begin
            if (draw_emit) begin
               rsp_valid_in = 1'b1;
               out_fill_in  = fill_ff;
               out_fcol_in  = fill_ff ? fcol_ff : '0;
               out_wv_in    = 1'b1;
               out_addr_in  = addr_ff;
               out_pcol_in  = bfr_pkg::rgba_to_argb(rdata_ff[bit_sel] ? fg_ff : bg_ff);
               out_last_in  = (pix_ff == bfr_pkg::PIX_CNT_W'(bfr_pkg::PIXEL_COUNT - 1));
               fill_in      = 1'b0;
               pix_in       = pix_ff + 1'b1;
               if (pix_col == 3'd7) begin
                  addr_in = addr_ff + AW'(SCREEN_W - (bfr_pkg::GLYPH_SIZE - 1));
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
               if (out_last_in) begin
                  col_in = col_ff + CW'(bfr_pkg::GLYPH_SIZE);
               end
            end
         end
         bfr_pkg::ST_FILL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_fill_in  = 1'b1;
               out_fcol_in  = fcol_ff;
               out_wv_in    = 1'b0;
               out_addr_in  = '0;
               out_pcol_in  = '0;
               out_last_in  = 1'b1;
               fill_in      = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfr_pkg::ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         fill_ff      <= 1'b0;
         pix_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         fill_ff      <= fill_in;
         pix_ff       <= pix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Color registers, written from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= bfr_pkg::FG_COLOR_RESET;
         bg_ff <= bfr_pkg::BG_COLOR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bfr_pkg::REG_FG_COLOR: fg_ff <= csr_wdata;
            bfr_pkg::REG_BG_COLOR: bg_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      fcol_ff     <= fcol_in;
      addr_ff     <= addr_in;
      out_fill_ff <= out_fill_in;
      out_fcol_ff <= out_fcol_in;
      out_wv_ff   <= out_wv_in;
      out_addr_ff <= out_addr_in;
      out_pcol_ff <= out_pcol_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, out_pcol_ff, out_addr_ff, out_fcol_ff};
   assign rsp_tuser  = {out_wv_ff, out_fill_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire
